### rtl/core/gec_pkg.sv
// ----------------------------------------------------------------------------
// gec_pkg
// Word types and command codes of the grammar emptiness checker.
// ----------------------------------------------------------------------------
package gec_pkg;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_SOLVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam int        APB_AW         = 2;
	localparam logic [1:0] REG_START_ADDR = 2'd0;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] head_symbol;
		logic [7:0] terminal_value;
		logic       terminal_present;
		logic [7:0] first_child;
		logic       first_present;
		logic [7:0] second_child;
		logic       second_present;
		logic [7:0] query_symbol;
	} in_word_t;

	typedef struct packed {
		logic       status;
		logic       start_generative;
		logic       symbol_generative;
		logic [7:0] witness_terminal;
		logic       witness_has_terminal;
		logic [7:0] witness_first;
		logic       witness_has_first;
		logic [7:0] witness_second;
		logic       witness_has_second;
	} out_word_t;

endpackage

### rtl/core/grammar_emptiness_checker_unit.sv
// ----------------------------------------------------------------------------
// grammar_emptiness_checker_unit
// Loads productions, solves grammar emptiness by a worklist over parent lists.
// ----------------------------------------------------------------------------
// channel  | dir | handshake                    | word
// in       | in  | in_valid / in_ready          | gec_pkg::in_word_t
// out      | out | out_valid / out_ready        | gec_pkg::out_word_t
// apb      | in  | psel penable pwrite / pready | start_symbol at 0x0
//
// After reset the symbol table is cleared while in_ready is low.
// Add: ST_ADD, then ST_MKG without children; with the table full straight to ST_EMIT;
// read: ST_RDQ, ST_RDS, ST_RDE; unsupported code: straight to ST_EMIT; each result
// then goes into the output register. Solve counts children, prefix-sums the counts,
// fills the parent lists and drains the queue; every memory read is registered.
// One word in flight; in_ready is high only when idle, results wait in the
// output register while out_ready is low.
module grammar_emptiness_checker_unit #(
	parameter int MAX_SYMBOLS     = 256,
	parameter int MAX_PRODUCTIONS = 4096,
	parameter int TERMINAL_BITS   = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  gec_pkg::in_word_t         in_word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output gec_pkg::out_word_t        out_word,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [gec_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import gec_pkg::*;

	localparam int S     = MAX_SYMBOLS;
	localparam int P     = MAX_PRODUCTIONS;
	localparam int LDEP  = 2 * P;
	localparam int SW    = $clog2(S);
	localparam int TW    = (TERMINAL_BITS < 8) ? TERMINAL_BITS : 8;
	localparam int PAW   = (P > 1) ? $clog2(P) : 1;
	localparam int CW    = $clog2(P + 1);
	localparam int LAW   = $clog2(LDEP);
	localparam int OW    = $clog2(LDEP + 1);
	localparam int CAW   = $clog2(S + 1);
	localparam int IW    = $clog2(S + 2);
	localparam int TLW   = $clog2(S + 1);

	typedef struct packed {
		logic          tp;
		logic [TW-1:0] term;
		logic          fp;
		logic [SW-1:0] first;
		logic          sp;
		logic [SW-1:0] second;
	} body_t;

	typedef struct packed {
		logic [SW-1:0] head;
		body_t         body;
	} prod_t;

	typedef struct packed {
		logic  gen;
		body_t body;
	} sym_t;

	typedef enum logic [28:0] {
		ST_CLR    = 29'b1 << 0,
		ST_IDLE   = 29'b1 << 1,
		ST_ADD    = 29'b1 << 2,
		ST_MKG    = 29'b1 << 3,
		ST_RDQ    = 29'b1 << 4,
		ST_RDS    = 29'b1 << 5,
		ST_RDE    = 29'b1 << 6,
		ST_EMIT   = 29'b1 << 7,
		ST_SCLR   = 29'b1 << 8,
		ST_CNT_RD = 29'b1 << 9,
		ST_CNT_F  = 29'b1 << 10,
		ST_CNT_FW = 29'b1 << 11,
		ST_CNT_SR = 29'b1 << 12,
		ST_CNT_SW = 29'b1 << 13,
		ST_PFX_RD = 29'b1 << 14,
		ST_PFX_WR = 29'b1 << 15,
		ST_FIL_RD = 29'b1 << 16,
		ST_FIL_F  = 29'b1 << 17,
		ST_FIL_FW = 29'b1 << 18,
		ST_FIL_SR = 29'b1 << 19,
		ST_FIL_SW = 29'b1 << 20,
		ST_DRN_Q  = 29'b1 << 21,
		ST_DRN_LO = 29'b1 << 22,
		ST_DRN_HI = 29'b1 << 23,
		ST_DRN_IT = 29'b1 << 24,
		ST_DRN_P  = 29'b1 << 25,
		ST_DRN_D  = 29'b1 << 26,
		ST_FIN    = 29'b1 << 27,
		ST_FIN_D  = 29'b1 << 28
	} state_t;

	function automatic logic [SW-1:0] sym_mod(input logic [7:0] v);
		int r;
		r = int'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (S << k))
				r = r - (S << k);
		end
		return SW'(r);
	endfunction

	state_t          state_q, ret_q;
	in_word_t        in_q;
	out_word_t       res_q, out_q;
	logic            ovld_q, solved_q;
	logic [7:0]      start_q;
	logic [CW-1:0]   count_q, p_q;
	logic [TLW-1:0]  tail_q, head_q;
	logic [IW-1:0]   idx_q;
	logic [OW-1:0]   acc_q, it_q;
	logic [SW-1:0]   mk_h_q;
	body_t           mk_body_q;

	body_t           nb;
	logic [SW-1:0]   nh, qsym, ssym;

	// memories
	prod_t           prod_mem [P];
	logic            prod_we, prod_re;
	logic [PAW-1:0]  prod_wa, prod_ra;
	prod_t           prod_wd, prod_rd;

	logic [1:0]      pend_mem [P];
	logic            pend_we, pend_re;
	logic [PAW-1:0]  pend_wa, pend_ra;
	logic [1:0]      pend_wd, pend_rd;

	logic [OW-1:0]   cnt_mem [S+1];
	logic            cnt_we, cnt_re;
	logic [CAW-1:0]  cnt_wa, cnt_ra;
	logic [OW-1:0]   cnt_wd, cnt_rd;

	logic [OW-1:0]   cur_mem [S+1];
	logic            cur_we, cur_re;
	logic [CAW-1:0]  cur_wa, cur_ra;
	logic [OW-1:0]   cur_wd, cur_rd;

	logic [PAW-1:0]  list_mem [LDEP];
	logic            list_we, list_re;
	logic [LAW-1:0]  list_wa, list_ra;
	logic [PAW-1:0]  list_wd, list_rd;

	sym_t            sym_mem [S];
	logic            sym_we, sym_re;
	logic [SW-1:0]   sym_wa, sym_ra;
	sym_t            sym_wd, sym_rd;

	logic [SW-1:0]   que_mem [S];
	logic            que_we, que_re;
	logic [SW-1:0]   que_wa, que_ra;
	logic [SW-1:0]   que_wd, que_rd;

	always_ff @(posedge clk) begin
		if (prod_we) prod_mem[prod_wa] <= prod_wd;
		if (prod_re) prod_rd <= prod_mem[prod_ra];
	end
	always_ff @(posedge clk) begin
		if (pend_we) pend_mem[pend_wa] <= pend_wd;
		if (pend_re) pend_rd <= pend_mem[pend_ra];
	end
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
	end
	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		if (cur_re) cur_rd <= cur_mem[cur_ra];
	end
	always_ff @(posedge clk) begin
		if (list_we) list_mem[list_wa] <= list_wd;
		if (list_re) list_rd <= list_mem[list_ra];
	end
	always_ff @(posedge clk) begin
		if (sym_we) sym_mem[sym_wa] <= sym_wd;
		if (sym_re) sym_rd <= sym_mem[sym_ra];
	end
	always_ff @(posedge clk) begin
		if (que_we) que_mem[que_wa] <= que_wd;
		if (que_re) que_rd <= que_mem[que_ra];
	end

	always_comb begin
		nh       = sym_mod(in_q.head_symbol);
		qsym     = sym_mod(in_q.query_symbol);
		ssym     = sym_mod(start_q);
		nb.tp    = in_q.terminal_present;
		nb.term  = in_q.terminal_present ? in_q.terminal_value[TW-1:0] : '0;
		nb.fp    = in_q.first_present;
		nb.first = in_q.first_present ? sym_mod(in_q.first_child) : '0;
		nb.sp    = in_q.second_present;
		nb.second = in_q.second_present ? sym_mod(in_q.second_child) : '0;
	end

	// memory port control
	always_comb begin
		prod_we = 1'b0; prod_wa = '0; prod_wd = '0; prod_re = 1'b0; prod_ra = '0;
		pend_we = 1'b0; pend_wa = '0; pend_wd = '0; pend_re = 1'b0; pend_ra = '0;
		cnt_we  = 1'b0; cnt_wa  = '0; cnt_wd  = '0; cnt_re  = 1'b0; cnt_ra  = '0;
		cur_we  = 1'b0; cur_wa  = '0; cur_wd  = '0; cur_re  = 1'b0; cur_ra  = '0;
		list_we = 1'b0; list_wa = '0; list_wd = '0; list_re = 1'b0; list_ra = '0;
		sym_we  = 1'b0; sym_wa  = '0; sym_wd  = '0; sym_re  = 1'b0; sym_ra  = '0;
		que_we  = 1'b0; que_wa  = '0; que_wd  = '0; que_re  = 1'b0; que_ra  = '0;
		case (state_q)
			ST_CLR: begin
				sym_we = 1'b1;
				sym_wa = SW'(idx_q);
			end
			ST_ADD: begin
				prod_we = 1'b1;
				prod_wa = PAW'(count_q);
				prod_wd = '{head: nh, body: nb};
				if (!nb.fp && !nb.sp) begin
					sym_re = 1'b1;
					sym_ra = nh;
				end
			end
			ST_MKG: begin
				if (!sym_rd.gen) begin
					sym_we = 1'b1;
					sym_wa = mk_h_q;
					sym_wd = '{gen: 1'b1, body: mk_body_q};
					if (tail_q < TLW'(S)) begin
						que_we = 1'b1;
						que_wa = SW'(tail_q);
						que_wd = mk_h_q;
					end
				end
			end
			ST_RDQ: begin
				sym_re = 1'b1;
				sym_ra = qsym;
			end
			ST_RDS, ST_FIN: begin
				sym_re = 1'b1;
				sym_ra = ssym;
			end
			ST_SCLR: begin
				cnt_we = 1'b1;
				cnt_wa = CAW'(idx_q);
			end
			ST_CNT_RD, ST_FIL_RD: begin
				if (p_q < count_q) begin
					prod_re = 1'b1;
					prod_ra = PAW'(p_q);
				end
			end
			ST_CNT_F: begin
				pend_we = 1'b1;
				pend_wa = PAW'(p_q);
				pend_wd = {1'b0, prod_rd.body.fp} + {1'b0, prod_rd.body.sp};
				if (prod_rd.body.fp) begin
					cnt_re = 1'b1;
					cnt_ra = CAW'(prod_rd.body.first) + CAW'(1);
				end
			end
			ST_CNT_FW: begin
				cnt_we = 1'b1;
				cnt_wa = CAW'(prod_rd.body.first) + CAW'(1);
				cnt_wd = cnt_rd + OW'(1);
			end
			ST_CNT_SR: begin
				cnt_re = 1'b1;
				cnt_ra = CAW'(prod_rd.body.second) + CAW'(1);
			end
			ST_CNT_SW: begin
				cnt_we = 1'b1;
				cnt_wa = CAW'(prod_rd.body.second) + CAW'(1);
				cnt_wd = cnt_rd + OW'(1);
			end
			ST_PFX_RD: begin
				if (idx_q <= IW'(S)) begin
					cnt_re = 1'b1;
					cnt_ra = CAW'(idx_q);
				end
			end
			ST_PFX_WR: begin
				cnt_we = 1'b1;
				cnt_wa = CAW'(idx_q);
				cnt_wd = acc_q + cnt_rd;
				cur_we = 1'b1;
				cur_wa = CAW'(idx_q);
				cur_wd = acc_q + cnt_rd;
			end
			ST_FIL_F: begin
				if (prod_rd.body.fp) begin
					cur_re = 1'b1;
					cur_ra = CAW'(prod_rd.body.first);
				end
			end
			ST_FIL_FW, ST_FIL_SW: begin
				if (cur_rd < OW'(LDEP)) begin
					list_we = 1'b1;
					list_wa = LAW'(cur_rd);
					list_wd = PAW'(p_q);
					cur_we  = 1'b1;
					cur_wa  = (state_q == ST_FIL_FW) ? CAW'(prod_rd.body.first)
					                                 : CAW'(prod_rd.body.second);
					cur_wd  = cur_rd + OW'(1);
				end
			end
			ST_FIL_SR: begin
				cur_re = 1'b1;
				cur_ra = CAW'(prod_rd.body.second);
			end
			ST_DRN_Q: begin
				if (head_q < tail_q && head_q < TLW'(S)) begin
					que_re = 1'b1;
					que_ra = SW'(head_q);
				end
			end
			ST_DRN_LO: begin
				cnt_re = 1'b1;
				cnt_ra = CAW'(que_rd);
			end
			ST_DRN_HI: begin
				cnt_re = 1'b1;
				cnt_ra = CAW'(que_rd) + CAW'(1);
			end
			ST_DRN_IT: begin
				if (it_q < cnt_rd && it_q < OW'(LDEP)) begin
					list_re = 1'b1;
					list_ra = LAW'(it_q);
				end
			end
			ST_DRN_P: begin
				if (CW'(list_rd) < count_q) begin
					pend_re = 1'b1;
					pend_ra = list_rd;
					prod_re = 1'b1;
					prod_ra = list_rd;
				end
			end
			ST_DRN_D: begin
				if (pend_rd != 2'd0) begin
					pend_we = 1'b1;
					pend_wa = list_rd;
					pend_wd = pend_rd - 2'd1;
					if (pend_rd == 2'd1) begin
						sym_re = 1'b1;
						sym_ra = prod_rd.head;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			ret_q    <= ST_EMIT;
			idx_q    <= '0;
			count_q  <= '0;
			tail_q   <= '0;
			head_q   <= '0;
			solved_q <= 1'b0;
			ovld_q   <= 1'b0;
			start_q  <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_START_ADDR)
				start_q <= pwdata[7:0];
			if (ovld_q && out_ready && state_q != ST_EMIT)
				ovld_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == IW'(S - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						in_q <= in_word;
						case (in_word.command)
							CMD_ADD: begin
								if (count_q >= CW'(P)) begin
									res_q   <= '{status: 1'b1, default: '0};
									state_q <= ST_EMIT;
								end else begin
									res_q   <= '0;
									state_q <= ST_ADD;
								end
							end
							CMD_SOLVE: begin
								res_q   <= '0;
								idx_q   <= '0;
								state_q <= ST_SCLR;
							end
							CMD_READ: begin
								res_q   <= '0;
								state_q <= ST_RDQ;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_ADD: begin
					count_q  <= count_q + CW'(1);
					solved_q <= 1'b0;
					if (!nb.fp && !nb.sp) begin
						mk_h_q    <= nh;
						mk_body_q <= nb;
						ret_q     <= ST_EMIT;
						state_q   <= ST_MKG;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_MKG: begin
					if (!sym_rd.gen && tail_q < TLW'(S))
						tail_q <= tail_q + TLW'(1);
					state_q <= ret_q;
				end
				ST_RDQ: state_q <= ST_RDS;
				ST_RDS: begin
					if (sym_rd.gen) begin
						res_q.symbol_generative    <= 1'b1;
						res_q.witness_terminal     <= 8'(sym_rd.body.term);
						res_q.witness_has_terminal <= sym_rd.body.tp;
						res_q.witness_first        <= 8'(sym_rd.body.first);
						res_q.witness_has_first    <= sym_rd.body.fp;
						res_q.witness_second       <= 8'(sym_rd.body.second);
						res_q.witness_has_second   <= sym_rd.body.sp;
					end
					state_q <= ST_RDE;
				end
				ST_RDE: begin
					if (solved_q)
						res_q.start_generative <= sym_rd.gen;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!ovld_q || out_ready) begin
						out_q   <= res_q;
						ovld_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCLR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == IW'(S)) begin
						p_q     <= '0;
						state_q <= ST_CNT_RD;
					end
				end
				ST_CNT_RD: begin
					if (p_q < count_q) begin
						state_q <= ST_CNT_F;
					end else begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_PFX_RD;
					end
				end
				ST_CNT_F: begin
					if (prod_rd.body.fp) begin
						state_q <= ST_CNT_FW;
					end else if (prod_rd.body.sp) begin
						state_q <= ST_CNT_SR;
					end else begin
						p_q     <= p_q + CW'(1);
						state_q <= ST_CNT_RD;
					end
				end
				ST_CNT_FW: begin
					if (prod_rd.body.sp) begin
						state_q <= ST_CNT_SR;
					end else begin
						p_q     <= p_q + CW'(1);
						state_q <= ST_CNT_RD;
					end
				end
				ST_CNT_SR: state_q <= ST_CNT_SW;
				ST_CNT_SW: begin
					p_q     <= p_q + CW'(1);
					state_q <= ST_CNT_RD;
				end
				ST_PFX_RD: begin
					if (idx_q <= IW'(S)) begin
						state_q <= ST_PFX_WR;
					end else begin
						p_q     <= '0;
						state_q <= ST_FIL_RD;
					end
				end
				ST_PFX_WR: begin
					acc_q   <= acc_q + cnt_rd;
					idx_q   <= idx_q + IW'(1);
					state_q <= ST_PFX_RD;
				end
				ST_FIL_RD: begin
					if (p_q < count_q) begin
						state_q <= ST_FIL_F;
					end else begin
						head_q  <= '0;
						state_q <= ST_DRN_Q;
					end
				end
				ST_FIL_F: begin
					if (prod_rd.body.fp) begin
						state_q <= ST_FIL_FW;
					end else if (prod_rd.body.sp) begin
						state_q <= ST_FIL_SR;
					end else begin
						p_q     <= p_q + CW'(1);
						state_q <= ST_FIL_RD;
					end
				end
				ST_FIL_FW: begin
					if (prod_rd.body.sp) begin
						state_q <= ST_FIL_SR;
					end else begin
						p_q     <= p_q + CW'(1);
						state_q <= ST_FIL_RD;
					end
				end
				ST_FIL_SR: state_q <= ST_FIL_SW;
				ST_FIL_SW: begin
					p_q     <= p_q + CW'(1);
					state_q <= ST_FIL_RD;
				end
				ST_DRN_Q: begin
					if (head_q < tail_q && head_q < TLW'(S)) begin
						head_q  <= head_q + TLW'(1);
						state_q <= ST_DRN_LO;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DRN_LO: state_q <= ST_DRN_HI;
				ST_DRN_HI: begin
					it_q    <= cnt_rd;
					state_q <= ST_DRN_IT;
				end
				ST_DRN_IT: begin
					if (it_q < cnt_rd && it_q < OW'(LDEP)) begin
						it_q    <= it_q + OW'(1);
						state_q <= ST_DRN_P;
					end else begin
						state_q <= ST_DRN_Q;
					end
				end
				ST_DRN_P: begin
					if (CW'(list_rd) < count_q)
						state_q <= ST_DRN_D;
					else
						state_q <= ST_DRN_IT;
				end
				ST_DRN_D: begin
					if (pend_rd == 2'd1) begin
						mk_h_q    <= prod_rd.head;
						mk_body_q <= prod_rd.body;
						ret_q     <= ST_DRN_IT;
						state_q   <= ST_MKG;
					end else begin
						state_q <= ST_DRN_IT;
					end
				end
				ST_FIN: state_q <= ST_FIN_D;
				ST_FIN_D: begin
					res_q.start_generative <= sym_rd.gen;
					solved_q               <= 1'b1;
					state_q                <= ST_EMIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovld_q;
	assign out_word  = out_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == REG_START_ADDR) ? {24'd0, start_q} : 32'd0;

endmodule

### rtl/core/gec_checker.sv
// ----------------------------------------------------------------------------
// gec_checker
// Port-level checks of the grammar emptiness checker.
// ----------------------------------------------------------------------------
module gec_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input gec_pkg::out_word_t         out_word
);
	import gec_pkg::*;

	// held word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// one word in flight
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status |->
			!out_word.start_generative && !out_word.symbol_generative)
		else $error("table-full word carries solve or read fields");

	a_witness_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.symbol_generative |->
			out_word.witness_terminal == 8'd0 && !out_word.witness_has_terminal &&
			out_word.witness_first == 8'd0 && !out_word.witness_has_first &&
			out_word.witness_second == 8'd0 && !out_word.witness_has_second)
		else $error("witness fields set without a generative symbol");

endmodule

bind grammar_emptiness_checker_unit gec_checker u_gec_checker (.*);
